[rtl/core/kabf_pkg.sv]
// ----------------------------------------------------------------------------
// kabf_pkg
// Shared types, op codes and fixed-point helpers for the angle/bias filter.
// ----------------------------------------------------------------------------
package kabf_pkg;

    localparam int DataW  = 32;             // state, sample and result width
    localparam int CfgW   = 31;             // configuration register width
    localparam int CfgIdxW = 2;             // configuration index width
    localparam int OpW    = 5;
    localparam int DivStepW = 5;            // counts the 32 quotient bits

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_Q_ANGLE = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_Q_BIAS  = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_R_MEAS  = 2'd2;
    localparam logic [CfgIdxW-1:0] CFG_DT      = 2'd3;

    // reset values, Q4.28
    localparam logic [CfgW-1:0]  Q_ANGLE_RST = 31'd268435;
    localparam logic [CfgW-1:0]  Q_BIAS_RST  = 31'd805306;
    localparam logic [CfgW-1:0]  R_MEAS_RST  = 31'd134217728;
    localparam logic [CfgW-1:0]  DT_RST      = 31'd2684354;
    localparam logic [DataW-1:0] ONE_Q428    = 32'h1000_0000;

    // datapath op codes
    localparam logic [OpW-1:0] OP_NONE        = 5'd0;
    localparam logic [OpW-1:0] OP_LOAD        = 5'd1;
    localparam logic [OpW-1:0] OP_MUL_RATE_DT = 5'd2;
    localparam logic [OpW-1:0] OP_ACC_ANG_PRD = 5'd3;
    localparam logic [OpW-1:0] OP_PDOT        = 5'd4;
    localparam logic [OpW-1:0] OP_MUL_PDOT_DT = 5'd5;
    localparam logic [OpW-1:0] OP_ACC_P00     = 5'd6;
    localparam logic [OpW-1:0] OP_MUL_P11_DT  = 5'd7;
    localparam logic [OpW-1:0] OP_ACC_P01_P10 = 5'd8;
    localparam logic [OpW-1:0] OP_MUL_QB_DT   = 5'd9;
    localparam logic [OpW-1:0] OP_ACC_P11     = 5'd10;
    localparam logic [OpW-1:0] OP_ERR         = 5'd11;
    localparam logic [OpW-1:0] OP_DIV_K0      = 5'd12;
    localparam logic [OpW-1:0] OP_DIV_STEP    = 5'd13;
    localparam logic [OpW-1:0] OP_GAIN_K0     = 5'd14;
    localparam logic [OpW-1:0] OP_DIV_K1      = 5'd15;
    localparam logic [OpW-1:0] OP_GAIN_K1     = 5'd16;
    localparam logic [OpW-1:0] OP_MUL_K0_P00  = 5'd17;
    localparam logic [OpW-1:0] OP_ACC_C00     = 5'd18;
    localparam logic [OpW-1:0] OP_MUL_K0_P01  = 5'd19;
    localparam logic [OpW-1:0] OP_ACC_C01     = 5'd20;
    localparam logic [OpW-1:0] OP_MUL_K1_P00  = 5'd21;
    localparam logic [OpW-1:0] OP_ACC_C10     = 5'd22;
    localparam logic [OpW-1:0] OP_MUL_K1_P01  = 5'd23;
    localparam logic [OpW-1:0] OP_ACC_C11     = 5'd24;
    localparam logic [OpW-1:0] OP_MUL_K0_ERR  = 5'd25;
    localparam logic [OpW-1:0] OP_ACC_ANGLE   = 5'd26;
    localparam logic [OpW-1:0] OP_MUL_K1_ERR  = 5'd27;
    localparam logic [OpW-1:0] OP_ACC_BIAS    = 5'd28;
    localparam logic [OpW-1:0] OP_RATE        = 5'd29;
    localparam logic [OpW-1:0] OP_OUT         = 5'd30;

    typedef struct packed {
        logic [OpW-1:0] op;
    } kabf_cmd_t;

    typedef struct packed {
        logic                    ovf;
        logic signed [DataW-1:0] val;
    } sat_t;

    // round half up of p / 2^28
    function automatic logic signed [35:0] rnd28(input logic signed [63:0] p);
        logic signed [63:0] s;
        s = p + 64'sd134217728;
        return s[63:28];
    endfunction

    // clamp to the signed 32-bit range
    function automatic sat_t sat40(input logic signed [39:0] v);
        sat_t r;
        if (v > 40'sd2147483647)
        begin
            r.ovf = 1'b1;
            r.val = 32'sh7fff_ffff;
        end
        else if (v < -40'sd2147483648)
        begin
            r.ovf = 1'b1;
            r.val = 32'sh8000_0000;
        end
        else
        begin
            r.ovf = 1'b0;
            r.val = v[31:0];
        end
        return r;
    endfunction

endpackage

[rtl/core/kabf_ctrl.sv]
// ----------------------------------------------------------------------------
// kabf_ctrl
// Sequencer: walks the op list per sample, loops the divider, owns handshakes.
// ----------------------------------------------------------------------------
module kabf_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output kabf_pkg::kabf_cmd_t cmd
);
    import kabf_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic [OpW-1:0]      pc_reg, pc_next;
    logic [DivStepW-1:0] cnt_reg, cnt_next;
    logic                out_valid_reg, out_valid_next;
    logic [OpW-1:0]      seq_next;

    // fixed op order of one sample
    always_comb
    begin
        unique case (pc_reg)
            OP_MUL_RATE_DT: seq_next = OP_ACC_ANG_PRD;
            OP_ACC_ANG_PRD: seq_next = OP_PDOT;
            OP_PDOT:        seq_next = OP_MUL_PDOT_DT;
            OP_MUL_PDOT_DT: seq_next = OP_ACC_P00;
            OP_ACC_P00:     seq_next = OP_MUL_P11_DT;
            OP_MUL_P11_DT:  seq_next = OP_ACC_P01_P10;
            OP_ACC_P01_P10: seq_next = OP_MUL_QB_DT;
            OP_MUL_QB_DT:   seq_next = OP_ACC_P11;
            OP_ACC_P11:     seq_next = OP_ERR;
            OP_ERR:         seq_next = OP_DIV_K0;
            OP_DIV_K0:      seq_next = OP_GAIN_K0;
            OP_GAIN_K0:     seq_next = OP_DIV_K1;
            OP_DIV_K1:      seq_next = OP_GAIN_K1;
            OP_GAIN_K1:     seq_next = OP_MUL_K0_P00;
            OP_MUL_K0_P00:  seq_next = OP_ACC_C00;
            OP_ACC_C00:     seq_next = OP_MUL_K0_P01;
            OP_MUL_K0_P01:  seq_next = OP_ACC_C01;
            OP_ACC_C01:     seq_next = OP_MUL_K1_P00;
            OP_MUL_K1_P00:  seq_next = OP_ACC_C10;
            OP_ACC_C10:     seq_next = OP_MUL_K1_P01;
            OP_MUL_K1_P01:  seq_next = OP_ACC_C11;
            OP_ACC_C11:     seq_next = OP_MUL_K0_ERR;
            OP_MUL_K0_ERR:  seq_next = OP_ACC_ANGLE;
            OP_ACC_ANGLE:   seq_next = OP_MUL_K1_ERR;
            OP_MUL_K1_ERR:  seq_next = OP_ACC_BIAS;
            OP_ACC_BIAS:    seq_next = OP_RATE;
            default:        seq_next = OP_MUL_RATE_DT;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        cnt_next   = cnt_reg;
        cmd.op     = OP_NONE;
        s_tready   = 1'b0;
        out_valid_next = out_valid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.op     = OP_LOAD;
                    pc_next    = OP_MUL_RATE_DT;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                cmd.op  = pc_reg;
                pc_next = seq_next;
                if (pc_reg == OP_DIV_K0 || pc_reg == OP_DIV_K1)
                begin
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
                else if (pc_reg == OP_RATE)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_DIV:
            begin
                cmd.op   = OP_DIV_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == '1)
                    state_next = ST_RUN;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    cmd.op         = OP_OUT;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pc_reg        <= OP_MUL_RATE_DT;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result register is only reloaded when its slot is free
    a_out_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_OUT) |-> (!out_valid_reg || m_tready))
        else $error("result overwritten before transfer");

    // one sample at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while a sample is in flight");

    // a new result appears only right after the output op
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.op == OP_OUT))
        else $error("result valid without output op");

    // the divide loop always returns to a gain op
    a_div_ret: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (pc_reg == OP_GAIN_K0 || pc_reg == OP_GAIN_K1))
        else $error("divide loop with bad return op");

endmodule

[rtl/core/kabf_datapath.sv]
// ----------------------------------------------------------------------------
// kabf_datapath
// Filter state, config registers, shared multiplier, serial divider, results.
// ----------------------------------------------------------------------------
module kabf_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  kabf_pkg::kabf_cmd_t                cmd,
    input  logic                               cfg_wr_en,
    input  logic [kabf_pkg::CfgIdxW-1:0]       cfg_addr,
    input  logic [kabf_pkg::CfgW-1:0]          cfg_wdata,
    input  logic signed [kabf_pkg::DataW-1:0]  accel_in,
    input  logic signed [kabf_pkg::DataW-1:0]  gyro_in,
    output logic signed [kabf_pkg::DataW-1:0]  angle_out,
    output logic signed [kabf_pkg::DataW-1:0]  rate_out,
    output logic                               sat_out
);
    import kabf_pkg::*;

    logic [CfgW-1:0] q_angle_reg, q_bias_reg, r_meas_reg, dt_reg;

    logic signed [DataW-1:0] angle_reg, bias_reg;
    logic signed [DataW-1:0] c00_reg, c01_reg, c10_reg, c11_reg;

    logic signed [DataW-1:0] accel_reg, gyro_reg, rate_reg, pdot_reg, err_reg;
    logic signed [DataW-1:0] p00_reg, p01_reg, p10_reg, p11_reg, k0_reg, k1_reg;
    logic signed [DataW:0]   e_reg;
    logic signed [63:0]      prod_reg;
    logic                    flag_reg;

    logic [DataW:0]   dvs_reg;       // divisor magnitude
    logic [DataW:0]   rem_reg;
    logic [DataW-1:0] quo_reg;       // low numerator bits, then quotient
    logic             qneg_reg, dovf_reg, dzero_reg;

    // shared multiplier
    logic signed [DataW-1:0] mul_a, mul_b, dt_s;
    assign dt_s = $signed({1'b0, dt_reg});

    always_comb
    begin
        mul_a = rate_reg;
        mul_b = dt_s;
        unique case (cmd.op)
            OP_MUL_PDOT_DT: begin mul_a = pdot_reg; mul_b = dt_s;    end
            OP_MUL_P11_DT:  begin mul_a = c11_reg;  mul_b = dt_s;    end
            OP_MUL_QB_DT:   begin mul_a = $signed({1'b0, q_bias_reg}); mul_b = dt_s; end
            OP_MUL_K0_P00:  begin mul_a = k0_reg;   mul_b = p00_reg; end
            OP_MUL_K0_P01:  begin mul_a = k0_reg;   mul_b = p01_reg; end
            OP_MUL_K1_P00:  begin mul_a = k1_reg;   mul_b = p00_reg; end
            OP_MUL_K1_P01:  begin mul_a = k1_reg;   mul_b = p01_reg; end
            OP_MUL_K0_ERR:  begin mul_a = k0_reg;   mul_b = err_reg; end
            OP_MUL_K1_ERR:  begin mul_a = k1_reg;   mul_b = err_reg; end
            default:        begin mul_a = rate_reg; mul_b = dt_s;    end
        endcase
    end

    // accumulate: base +/- rounded product, clamped
    logic signed [35:0]      rnd;
    logic signed [DataW-1:0] acc_base;
    logic                    acc_sub;
    sat_t                    acc_res, acc_p10;

    assign rnd = rnd28(prod_reg);

    always_comb
    begin
        acc_base = angle_reg;
        acc_sub  = 1'b0;
        unique case (cmd.op)
            OP_ACC_P00:     acc_base = c00_reg;
            OP_ACC_P01_P10: begin acc_base = c01_reg; acc_sub = 1'b1; end
            OP_ACC_P11:     acc_base = c11_reg;
            OP_ACC_C00:     begin acc_base = p00_reg; acc_sub = 1'b1; end
            OP_ACC_C01:     begin acc_base = p01_reg; acc_sub = 1'b1; end
            OP_ACC_C10:     begin acc_base = p10_reg; acc_sub = 1'b1; end
            OP_ACC_C11:     begin acc_base = p11_reg; acc_sub = 1'b1; end
            OP_ACC_BIAS:    acc_base = bias_reg;
            default:        acc_base = angle_reg;
        endcase
        if (acc_sub)
            acc_res = sat40(40'(acc_base) - 40'(rnd));
        else
            acc_res = sat40(40'(acc_base) + 40'(rnd));
        acc_p10 = sat40(40'(c10_reg) - 40'(rnd));
    end

    // differences
    sat_t load_rate, new_rate, pdot_res, err_res;
    assign load_rate = sat40(40'(gyro_in) - 40'(bias_reg));
    assign new_rate  = sat40(40'(gyro_reg) - 40'(bias_reg));
    assign pdot_res  = sat40(40'($signed({1'b0, q_angle_reg})) - 40'(c01_reg)
                             - 40'(c10_reg));
    assign err_res   = sat40(40'(accel_reg) - 40'(angle_reg));

    // divider setup: |num| * 2^28 / |e|
    logic signed [DataW-1:0] div_num;
    logic [DataW-1:0]        num_mag;
    logic [59:0]             n_mag;
    logic [DataW:0]          e_mag;
    logic                    pre_ovf;

    always_comb
    begin
        div_num = (cmd.op == OP_DIV_K1) ? p10_reg : p00_reg;
        num_mag = div_num[DataW-1] ? (~div_num + 1'b1) : div_num;
        n_mag   = {num_mag, 28'd0};
        e_mag   = e_reg[DataW] ? (~e_reg + 1'b1) : e_reg;
        pre_ovf = {5'd0, n_mag} >= {e_mag, 32'd0};
    end

    // one quotient bit per step
    logic [DataW+1:0] trial;
    logic             ge;
    assign trial = {rem_reg, quo_reg[DataW-1]};
    assign ge    = trial >= {1'b0, dvs_reg};

    // gain from quotient
    logic signed [DataW+1:0] q_signed;
    sat_t                    q_sat;
    sat_t                    gain;

    always_comb
    begin
        q_signed = $signed({2'b00, quo_reg});
        if (qneg_reg)
            q_signed = -q_signed;
        q_sat = sat40(40'(q_signed));
        if (dzero_reg)
        begin
            gain.ovf = 1'b1;
            gain.val = '0;
        end
        else if (dovf_reg)
        begin
            gain.ovf = 1'b1;
            gain.val = qneg_reg ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end
        else
        begin
            gain = q_sat;
        end
    end

    // saturation flag contribution of this op
    logic op_ovf;
    always_comb
    begin
        unique case (cmd.op)
            OP_ACC_ANG_PRD, OP_ACC_P00, OP_ACC_P11, OP_ACC_C00, OP_ACC_C01,
            OP_ACC_C10, OP_ACC_C11, OP_ACC_ANGLE, OP_ACC_BIAS:
                op_ovf = acc_res.ovf;
            OP_ACC_P01_P10: op_ovf = acc_res.ovf || acc_p10.ovf;
            OP_PDOT:        op_ovf = pdot_res.ovf;
            OP_ERR:         op_ovf = err_res.ovf;
            OP_GAIN_K0, OP_GAIN_K1: op_ovf = gain.ovf;
            OP_RATE:        op_ovf = new_rate.ovf;
            default:        op_ovf = 1'b0;
        endcase
    end

    // config and filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_angle_reg <= Q_ANGLE_RST;
            q_bias_reg  <= Q_BIAS_RST;
            r_meas_reg  <= R_MEAS_RST;
            dt_reg      <= DT_RST;
            angle_reg   <= '0;
            bias_reg    <= '0;
            c00_reg     <= ONE_Q428;
            c01_reg     <= '0;
            c10_reg     <= '0;
            c11_reg     <= ONE_Q428;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (cfg_addr)
                    CFG_Q_ANGLE: q_angle_reg <= cfg_wdata;
                    CFG_Q_BIAS:  q_bias_reg  <= cfg_wdata;
                    CFG_R_MEAS:  r_meas_reg  <= cfg_wdata;
                    CFG_DT:      dt_reg      <= cfg_wdata;
                    default:     dt_reg      <= dt_reg;
                endcase
            end
            unique case (cmd.op)
                OP_ACC_ANG_PRD, OP_ACC_ANGLE: angle_reg <= acc_res.val;
                OP_ACC_BIAS: bias_reg <= acc_res.val;
                OP_ACC_C00:  c00_reg  <= acc_res.val;
                OP_ACC_C01:  c01_reg  <= acc_res.val;
                OP_ACC_C10:  c10_reg  <= acc_res.val;
                OP_ACC_C11:  c11_reg  <= acc_res.val;
                default:     angle_reg <= angle_reg;
            endcase
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_LOAD)
            flag_reg <= load_rate.ovf;
        else
            flag_reg <= flag_reg | op_ovf;

        unique case (cmd.op)
            OP_LOAD:
            begin
                accel_reg <= accel_in;
                gyro_reg  <= gyro_in;
                rate_reg  <= load_rate.val;
            end
            OP_MUL_RATE_DT, OP_MUL_PDOT_DT, OP_MUL_P11_DT, OP_MUL_QB_DT,
            OP_MUL_K0_P00, OP_MUL_K0_P01, OP_MUL_K1_P00, OP_MUL_K1_P01,
            OP_MUL_K0_ERR, OP_MUL_K1_ERR:
                prod_reg <= mul_a * mul_b;
            OP_PDOT:        pdot_reg <= pdot_res.val;
            OP_ACC_P00:     p00_reg  <= acc_res.val;
            OP_ACC_P01_P10:
            begin
                p01_reg <= acc_res.val;
                p10_reg <= acc_p10.val;
            end
            OP_ACC_P11:     p11_reg  <= acc_res.val;
            OP_ERR:
            begin
                err_reg <= err_res.val;
                e_reg   <= $signed({2'b00, r_meas_reg}) + 33'(p00_reg);
            end
            OP_DIV_K0, OP_DIV_K1:
            begin
                dvs_reg   <= e_mag;
                rem_reg   <= {5'd0, n_mag[59:32]};
                quo_reg   <= n_mag[31:0];
                qneg_reg  <= div_num[DataW-1] ^ e_reg[DataW];
                dovf_reg  <= pre_ovf;
                dzero_reg <= (e_reg == '0);
            end
            OP_DIV_STEP:
            begin
                rem_reg <= ge ? 33'(trial - {1'b0, dvs_reg}) : trial[DataW:0];
                quo_reg <= {quo_reg[DataW-2:0], ge};
            end
            OP_GAIN_K0:     k0_reg   <= gain.val;
            OP_GAIN_K1:     k1_reg   <= gain.val;
            OP_RATE:        rate_reg <= new_rate.val;
            OP_OUT:
            begin
                angle_out <= angle_reg;
                rate_out  <= rate_reg;
                sat_out   <= flag_reg;
            end
            default:        rate_reg <= rate_reg;
        endcase
    end

endmodule

[rtl/core/kalman_angle_bias_fusion.sv]
// ----------------------------------------------------------------------------
// kalman_angle_bias_fusion
// Two-state Kalman filter fusing accelerometer tilt with gyro rate and bias.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake          | payload
//  s_*      | in  | s_tvalid/s_tready  | tdata: accel_angle, gyro_rate
//  m_*      | out | m_tvalid/m_tready  | tdata: angle_estimate, corrected_rate;
//           |     |                    | tuser: saturated
//  cfg_*    | in  | cfg_wr_en          | cfg_addr 0..3, cfg_wdata 31 bits
//
//  One sample runs from transfer in to result ready as: the load at the
//  transfer edge, the sequenced ops with two serial gain divisions among
//  them (one quotient bit a cycle), then the output load. Multiplies share
//  one 32x32 unit, each followed by its accumulate op. The result sits in
//  an output register; a stalled m side holds the block only at the final
//  output load. Reset (async, active low) restores angle 0, bias 0, P =
//  identity and the default noise settings.
// ----------------------------------------------------------------------------
module kalman_angle_bias_fusion (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [63:0]                   s_tdata,   // accel_angle, gyro_rate
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [63:0]                   m_tdata,   // angle_estimate, corrected_rate
    output logic                          m_tuser,   // saturated
    input  logic                          cfg_wr_en,
    input  logic [kabf_pkg::CfgIdxW-1:0]  cfg_addr,
    input  logic [kabf_pkg::CfgW-1:0]     cfg_wdata
);
    import kabf_pkg::*;

    kabf_cmd_t               cmd;
    logic signed [DataW-1:0] angle_out, rate_out;
    logic                    sat_out;

    // sequencer: one transfer in, the op list, one transfer out
    kabf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // arithmetic, filter state and result register
    kabf_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .accel_in  ($signed(s_tdata[31:0])),
        .gyro_in   ($signed(s_tdata[63:32])),
        .angle_out (angle_out),
        .rate_out  (rate_out),
        .sat_out   (sat_out)
    );

    assign m_tdata = {rate_out, angle_out};
    assign m_tuser = sat_out;

endmodule
